// ===== rtl/sbsh_pkg.sv =====
// Package for the SHA-256 byte stream hasher: queue entry type, back-end status,
// initial hash values, round constants and the SHA-256 bit functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbsh_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic busy;
    logic out_valid;
  } core_stat_t;

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: front end, entry queue, hash core.
// Depends on sbsh_pkg, sbsh_front, sbsh_queue and sbsh_core.
//
//   channel   ports                                  transfer when
//   input     push, full, data_byte, has_byte, last  push && !full
//   result    empty, pop, digest_word, word_index,   pop && !empty
//             last_word
//
// The core takes one queued byte per cycle while it is idle; a full 64-byte block then
// runs the compression and is folded into the chaining value.
// A last item adds padding bytes up to the block end, and one or
// two compressions, before eight digest words are offered in turn.
// The front queue keeps taking items while it has room, also while the core compresses or waits on pop.
// rst is synchronous and returns the hash state to the initial values.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher
  import sbsh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        last,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  entry_t     wr_entry;
  entry_t     rd_entry;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  core_stat_t stat;

  sbsh_front u_front (
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .q_push    (q_push),
    .q_entry   (wr_entry),
    .q_full    (q_full)
  );

  sbsh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_entry (rd_entry),
    .empty    (q_empty)
  );

  sbsh_core u_core (
    .clk         (clk),
    .rst         (rst),
    .q_entry     (rd_entry),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word),
    .stat        (stat)
  );

  // The core pulls from the queue only when it is free to take a byte.
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (stat.idle && !q_empty))
    else $error("queue read while core not idle");

  // A digest always starts with the most significant word.
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(stat.out_valid) |-> (word_index == 3'd0))
    else $error("digest did not start at word 0");

  // Taking the final word ends the digest.
  a_last_word_ends: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_word) |=> (empty && stat.idle))
    else $error("digest output continued past last word");

endmodule
`default_nettype wire

// ===== rtl/sbsh_front.sv =====
// Front end: takes input transfers, drops items that carry neither a byte nor
// the end of a message, and forms queue entries. Depends on sbsh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbsh_front
  import sbsh_pkg::*;
(
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       has_byte,
  input  wire logic       last,
  output logic            q_push,
  output entry_t          q_entry,
  input  wire logic       q_full
);

  assign full    = q_full;
  // An item with no byte that does not end the message changes nothing.
  assign q_push  = push && !q_full && (has_byte || last);
  assign q_entry = '{data: data_byte, has_byte: has_byte, last: last};

endmodule
`default_nettype wire

// ===== rtl/sbsh_queue.sv =====
// Short queue of classified entries between the front end and the hash core.
// Depends on sbsh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbsh_queue
  import sbsh_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  entry_t      wr_entry,
  output logic        full,
  input  wire logic   rd_en,
  output entry_t      rd_entry,
  output logic        empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sbsh_core.sv =====
// Hash core: block buffer, padding, 64-round compression at one round per cycle
// and the digest word output. Depends on sbsh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbsh_core
  import sbsh_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  entry_t      q_entry,
  input  wire logic   q_empty,
  output logic        q_pop,
  output logic        empty,
  input  wire logic   pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output core_stat_t  stat
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [23:0] part;
  logic [31:0] sched [16];
  logic [31:0] chain [8];
  logic [31:0] work  [8];
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic        pad_active;
  logic        sent80;
  logic        len_phase;
  logic        final_block;

  logic        app_en;
  logic [7:0]  app_byte;
  logic [7:0]  pad_byte;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] sched_new;
  logic        len_now;

  assign q_pop = (state == ST_IDLE) && !q_empty;

  // Once the 0x80 marker is placed, the length field starts at offset 56.
  assign len_now  = sent80 && ((fill == 6'd56) || len_phase);
  assign pad_byte = !sent80 ? 8'h80 :
                    len_now ? message_bits[{3'd7 - fill[2:0], 3'b000} +: 8] : 8'h00;

  always_comb begin
    app_en   = 1'b0;
    app_byte = pad_byte;
    case (state)
      ST_IDLE: begin
        app_en   = q_pop && q_entry.has_byte;
        app_byte = q_entry.data;
      end
      ST_PAD: begin
        app_en = 1'b1;
      end
      default: begin
        app_en = 1'b0;
      end
    endcase
  end

  assign t1 = work[7] + big_sigma1(work[4]) + ((work[4] & work[5]) ^ (~work[4] & work[6]))
            + ROUND_K[round] + sched[0];
  assign t2 = big_sigma0(work[0])
            + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
  assign sched_new = sched[0] + small_sigma0(sched[1]) + sched[9] + small_sigma1(sched[14]);

  // Payload storage: block words and working variables.
  always_ff @(posedge clk) begin
    if (app_en) begin
      part <= {part[15:0], app_byte};
      if (fill[1:0] == 2'b11) begin
        sched[fill[5:2]] <= {part, app_byte};
      end
    end
    if (app_en && fill == 6'd63) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= chain[i];
      end
    end
    if (state == ST_COMP) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[15] <= sched_new;
      work[0] <= t1 + t2;
      work[1] <= work[0];
      work[2] <= work[1];
      work[3] <= work[2];
      work[4] <= work[3] + t1;
      work[5] <= work[4];
      work[6] <= work[5];
      work[7] <= work[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      message_bits <= '0;
      round        <= '0;
      out_idx      <= '0;
      pad_active   <= 1'b0;
      sent80       <= 1'b0;
      len_phase    <= 1'b0;
      final_block  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= IV_WORDS[i];
      end
    end else begin
      if (app_en) begin
        fill <= fill + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_entry.has_byte) begin
              message_bits <= message_bits + 64'd8;
            end
            if (q_entry.last) begin
              pad_active <= 1'b1;
            end
            if (q_entry.has_byte && fill == 6'd63) begin
              state <= ST_COMP;
              round <= '0;
            end else if (q_entry.last) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          sent80 <= 1'b1;
          if (len_now) begin
            len_phase <= 1'b1;
          end
          if (fill == 6'd63) begin
            final_block <= len_now;
            state       <= ST_COMP;
            round       <= '0;
          end
        end
        ST_COMP: begin
          round <= round + 1'b1;
          if (round == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (final_block) begin
            state   <= ST_OUT;
            out_idx <= '0;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (pop) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == 3'd7) begin
              state        <= ST_IDLE;
              message_bits <= '0;
              pad_active   <= 1'b0;
              sent80       <= 1'b0;
              len_phase    <= 1'b0;
              final_block  <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= IV_WORDS[i];
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign empty       = (state != ST_OUT);
  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  assign stat = '{idle: (state == ST_IDLE),
                  busy: (state == ST_COMP) || (state == ST_FOLD) || (state == ST_PAD),
                  out_valid: (state == ST_OUT)};

endmodule
`default_nettype wire

// ===== dv/sha256_byte_stream_hasher_test.sv =====
// Self-checking test of the SHA-256 byte stream hasher: byte messages are pushed
// in, each digest word popped out is compared with a digest computed here.
// Depends on sbsh_pkg (for the compile order only) and the hasher RTL.
`timescale 1ns / 1ps

class digest_scoreboard;
  int unsigned h_state [8];
  byte unsigned blk [64];
  int unsigned fill;
  longint unsigned msg_bits;
  logic [31:0] exp_word [$];
  logic [2:0] exp_index [$];
  logic exp_lastw [$];
  int errors;
  int digests_seen;

  function void clear_message();
    h_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill = 0;
    msg_bits = 0;
  endfunction

  function new();
    errors = 0;
    digests_seen = 0;
    clear_message();
  endfunction

  function automatic int unsigned rotr(int unsigned v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void compress();
    int unsigned kk [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    int unsigned w [64];
    int unsigned r [8];
    int unsigned t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-7]
             + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    r = h_state;
    for (int t = 0; t < 64; t++) begin
      t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
           + ((r[4] & r[5]) ^ (~r[4] & r[6])) + kk[t] + w[t];
      t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
           + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      h_state[i] += r[i];
  endfunction

  function void add_byte(byte unsigned b);
    blk[fill] = b;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endfunction

  // Note one accepted input transfer and queue the digest words it causes.
  function void note_input(logic [7:0] data, logic hb, logic lst);
    longint unsigned len;
    if (hb) begin
      add_byte(data);
      msg_bits += 8;
    end
    if (!lst)
      return;
    len = msg_bits;
    add_byte(8'h80);
    while (fill != 56)
      add_byte(8'h00);
    for (int i = 0; i < 8; i++)
      add_byte(8'(len >> (56 - 8 * i)));
    for (int i = 0; i < 8; i++) begin
      exp_word.push_back(h_state[i]);
      exp_index.push_back(3'(i));
      exp_lastw.push_back(i == 7);
    end
    clear_message();
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_word(logic [31:0] dw, logic [2:0] idx, logic lw);
    if (exp_word.size() == 0) begin
      report($sformatf("unexpected digest word %h", dw));
      return;
    end
    if (dw !== exp_word[0])
      report($sformatf("digest_word %h, wanted %h", dw, exp_word[0]));
    if (idx !== exp_index[0])
      report($sformatf("word_index %0d, wanted %0d", idx, exp_index[0]));
    if (lw !== exp_lastw[0])
      report($sformatf("last_word %b, wanted %b", lw, exp_lastw[0]));
    if (exp_lastw[0])
      digests_seen++;
    void'(exp_word.pop_front());
    void'(exp_index.pop_front());
    void'(exp_lastw.pop_front());
  endtask
endclass

module sha256_byte_stream_hasher_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic has_byte = 1'b0;
  logic last = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [31:0] digest_word;
  logic [2:0] word_index;
  logic last_word;

  digest_scoreboard sb = new();
  int idle_pct = 35;
  bit hold_pop = 1'b0;
  int quiet_cycles = 0;
  localparam int QUIET_LIMIT = 20000;

  sha256_byte_stream_hasher u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .has_byte(has_byte), .last(last), .empty(empty), .pop(pop),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one item until it is taken; random gaps come before the offer.
  task automatic send_item(logic [7:0] d, logic hb, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= d;
    has_byte <= hb;
    last <= lst;
    do @(posedge clk); while (full);
    sb.note_input(d, hb, lst);
    @(negedge clk);
  endtask

  task automatic send_message(int len, logic trailing_empty);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(255)), 1'b1, !trailing_empty && i == len - 1);
    if (trailing_empty || len == 0)
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Receiver: random pop, except while a hold-off is in force.
  always @(negedge clk) begin
    if (rst || hold_pop)
      pop <= 1'b0;
    else
      pop <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty)
        sb.check_word(digest_word, word_index, last_word);
      if ((push && !full) || (pop && !empty))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty message, ignored items, byte extremes, padding borders.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'haa, 1'b0, 1'b1);
    send_message(56, 1'b0);

    // A full block ending on the last byte, with no idling on either side.
    idle_pct = 0;
    send_message(64, 1'b0);
    idle_pct = 35;

    // Hold the receiver off while the sender keeps offering.
    hold_pop = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_pop = 1'b0;
      end
      begin
        send_message(1, 1'b0);
        send_message(55, 1'b0);
      end
    join

    // Random short messages.
    n = 0;
    while (n < 20) begin
      int len;
      len = $urandom_range(0, 8);
      if ($urandom_range(7) == 0)
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_message(len, $urandom_range(3) == 0);
      n += len + 1;
    end
    push <= 1'b0;

    wait (sb.exp_word.size() == 0);
    repeat (200) @(posedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
